>>> src/scc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_pkg: shared types and constants of the simplex circumcenter engine
// Coordinate and intermediate widths, beat structs and register decode.
// ---------------------------------------------------------------------------
package scc_pkg;

  // Vertex coordinates are signed Q7.8.
  localparam int COORD_WIDTH  = 16;
  localparam int CENTER_WIDTH = 32;

  // Exact widths of the intermediate values.
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
  localparam int RHS_WIDTH   = 2 * COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int COF_WIDTH   = 2 * DIFF_WIDTH + 1;
  localparam int DEN_WIDTH   = DIFF_WIDTH + COF_WIDTH + 2;
  localparam int NUM_WIDTH   = RHS_WIDTH + COF_WIDTH + 2;

  // Multiplier digit size and stage count for a cofactor operand.
  localparam int MUL_DIGIT  = 16;
  localparam int MUL_STAGES = (COF_WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;

  // Quotient bits produced by the divider; one more bit flags overflow.
  localparam int QUO_BITS = 33;
  localparam int DIV_LAT  = QUO_BITS + 1;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);

  // Configuration decode: register index is paddr[CFG_IDX_BIT].
  localparam int   CFG_ADDR_WIDTH  = 3;
  localparam int   CFG_IDX_BIT     = 2;
  localparam logic REG_THREE_D_IDX = 1'b0;

  typedef logic signed [COORD_WIDTH-1:0]  coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]   diff_t;
  typedef logic signed [SQ_WIDTH-1:0]     sq_t;
  typedef logic signed [RHS_WIDTH-1:0]    rhs_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [COF_WIDTH-1:0]    cof_t;
  typedef logic signed [CENTER_WIDTH-1:0] center_t;

  // Input beat: one simplex.
  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    coord_t v3_x;
    coord_t v3_y;
    coord_t v3_z;
  } scc_in_t;

  // Result beat.
  typedef struct packed {
    center_t center_x;
    center_t center_y;
    center_t center_z;
    logic    degenerate;
  } scc_out_t;

  // Linear system handed from front to back: edge vectors and right sides.
  typedef struct packed {
    logic                three_d;
    diff_t [2:0][2:0]    n;
    rhs_t  [2:0]         rhs;
  } scc_sys_t;

endpackage

>>> src/scc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_front: input capture and linear system setup
// Registers each simplex, forms edge vectors and squared coordinates, then
// sums the right-hand sides for the active mode and pushes to the queue.
// ---------------------------------------------------------------------------
module scc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  scc_pkg::scc_in_t               vertices,
  input  logic                           three_d,
  input  logic [scc_pkg::CNT_WIDTH-1:0]  queue_count,
  output logic                           push,
  output scc_pkg::scc_sys_t              sys
);
  import scc_pkg::*;

  logic                 s1_valid;
  scc_in_t              s1_in;
  coord_t               v [4][3];
  logic                 s2_valid;
  diff_t [2:0][2:0]     s2_n;
  sq_t   [3:0][2:0]     s2_sq;
  logic                 s2_three_d;
  rhs_t  [2:0]          rhs;
  logic [CNT_WIDTH:0]   load;

  // Hold off new beats when the queue could not take everything in flight.
  assign load = (CNT_WIDTH+1)'(queue_count) + (CNT_WIDTH+1)'(s1_valid)
              + (CNT_WIDTH+1)'(s2_valid);
  assign busy = load >= (CNT_WIDTH+1)'(QUEUE_DEPTH);

  // Capture stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
    s1_in <= vertices;
  end

  assign v[0][0] = s1_in.v0_x;
  assign v[0][1] = s1_in.v0_y;
  assign v[0][2] = s1_in.v0_z;
  assign v[1][0] = s1_in.v1_x;
  assign v[1][1] = s1_in.v1_y;
  assign v[1][2] = s1_in.v1_z;
  assign v[2][0] = s1_in.v2_x;
  assign v[2][1] = s1_in.v2_y;
  assign v[2][2] = s1_in.v2_z;
  assign v[3][0] = s1_in.v3_x;
  assign v[3][1] = s1_in.v3_y;
  assign v[3][2] = s1_in.v3_z;

  // Edge vectors and squares, registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_three_d <= three_d;
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        s2_n[k][c] <= DIFF_WIDTH'(v[k+1][c]) - DIFF_WIDTH'(v[0][c]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        s2_sq[k][c] <= v[k][c] * v[k][c];
      end
    end
  end

  // Right-hand sides: z terms only count in tetrahedron mode.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rhs[k] = (RHS_WIDTH'(s2_sq[k+1][0]) - RHS_WIDTH'(s2_sq[0][0]))
             + (RHS_WIDTH'(s2_sq[k+1][1]) - RHS_WIDTH'(s2_sq[0][1]));
      if (s2_three_d) begin
        rhs[k] = rhs[k] + (RHS_WIDTH'(s2_sq[k+1][2]) - RHS_WIDTH'(s2_sq[0][2]));
      end
    end
  end

  assign push        = s2_valid;
  assign sys.three_d = s2_three_d;
  assign sys.n       = s2_n;
  assign sys.rhs     = rhs;

endmodule

>>> src/scc_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_queue: short register queue between front and back
// Holds prepared systems; the back takes the head beat in every cycle that the queue is not empty.
// ---------------------------------------------------------------------------
module scc_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  scc_pkg::scc_sys_t              sys_in,
  output logic                           valid,
  output scc_pkg::scc_sys_t              sys_out,
  output logic [scc_pkg::CNT_WIDTH-1:0]  count
);
  import scc_pkg::*;

  scc_sys_t              entry [QUEUE_DEPTH];
  logic [PTR_WIDTH-1:0]  wr_ptr;
  logic [PTR_WIDTH-1:0]  rd_ptr;
  logic                  pop;

  assign valid   = count != '0;
  assign pop     = valid;
  assign sys_out = entry[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_WIDTH'(push) - CNT_WIDTH'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= sys_in;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNT_WIDTH'(QUEUE_DEPTH))
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_WIDTH'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

>>> src/scc_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_mul: pipelined signed multiplier
// Walks the second operand one digit per stage and accumulates partial
// products, registering the running sum after each digit.
// ---------------------------------------------------------------------------
module scc_mul #(
  parameter int AW = 17,
  parameter int BW = 35
) (
  input  logic                  clk,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic signed [AW+BW-1:0] p
);
  import scc_pkg::*;

  localparam int NDIG = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BXW  = NDIG * MUL_DIGIT;
  localparam int PW   = AW + BW;
  localparam int SW   = PW + MUL_DIGIT + 1;

  logic signed [AW-1:0]  a_s   [NDIG];
  logic signed [BXW-1:0] b_s   [NDIG];
  logic signed [SW-1:0]  acc_s [NDIG+1];

  assign a_s[0]   = a;
  assign b_s[0]   = BXW'(b);
  assign acc_s[0] = '0;

  for (genvar i = 0; i < NDIG; i++) begin : g_dig
    logic signed [MUL_DIGIT:0]    digit;
    logic signed [AW+MUL_DIGIT:0] pp;

    // Lower digits are unsigned, the top digit carries the sign.
    if (i == NDIG - 1) begin : g_top
      assign digit = {b_s[i][BXW-1], b_s[i][i*MUL_DIGIT +: MUL_DIGIT]};
    end else begin : g_low
      assign digit = {1'b0, b_s[i][i*MUL_DIGIT +: MUL_DIGIT]};
    end
    assign pp = a_s[i] * digit;

    always_ff @(posedge clk) begin
      acc_s[i+1] <= acc_s[i] + (SW'(pp) <<< (MUL_DIGIT * i));
    end

    if (i < NDIG - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        a_s[i+1] <= a_s[i];
        b_s[i+1] <= b_s[i];
      end
    end
  end

  assign p = acc_s[NDIG][PW-1:0];

endmodule

>>> src/scc_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_div: pipelined rounding divider with saturation
// Computes round(num * 128 / den), ties away from zero, one quotient bit per
// stage, and saturates to a signed 32-bit result.
// ---------------------------------------------------------------------------
module scc_div #(
  parameter int NUM_W = 72,
  parameter int DEN_W = 54
) (
  input  logic                                  clk,
  input  logic signed [NUM_W-1:0]               num,
  input  logic signed [DEN_W-1:0]               den,
  output logic signed [scc_pkg::CENTER_WIDTH-1:0] q
);
  import scc_pkg::*;

  localparam int XW = NUM_W + 9;
  localparam int YW = DEN_W + QUO_BITS + 2;
  localparam int RW = (XW > YW) ? XW : YW;

  logic [NUM_W-1:0]     num_mag;
  logic [DEN_W-1:0]     den_mag;
  logic [RW-1:0]        x_val;
  logic [RW-1:0]        y_val;
  logic [RW-1:0]        rem   [QUO_BITS];
  logic [RW-1:0]        div_y [QUO_BITS];
  logic [QUO_BITS-1:0]  qacc  [QUO_BITS+1];
  logic                 neg_s [QUO_BITS+1];
  logic                 ovf_s [QUO_BITS+1];
  logic [CENTER_WIDTH-1:0] lim;
  logic [CENTER_WIDTH-1:0] q_low;
  logic                 over;

  // Magnitudes; dividend is 2|num|*128 + |den| over divisor 2|den|.
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign x_val   = (RW'(num_mag) << 8) + RW'(den_mag);
  assign y_val   = RW'(den_mag) << 1;

  // Setup stage, with an early check for quotients that need too many bits.
  always_ff @(posedge clk) begin
    rem[0]   <= x_val;
    div_y[0] <= y_val;
    qacc[0]  <= '0;
    neg_s[0] <= num[NUM_W-1] ^ den[DEN_W-1];
    ovf_s[0] <= x_val >= (y_val << QUO_BITS);
  end

  // Restoring division, most significant quotient bit first.
  for (genvar i = 0; i < QUO_BITS; i++) begin : g_bit
    localparam int SH = QUO_BITS - 1 - i;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = div_y[i] << SH;
    assign take  = rem[i] >= trial;

    always_ff @(posedge clk) begin
      qacc[i+1]  <= qacc[i] | (QUO_BITS'(take) << SH);
      neg_s[i+1] <= neg_s[i];
      ovf_s[i+1] <= ovf_s[i];
    end

    if (i < QUO_BITS - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem[i+1]   <= take ? rem[i] - trial : rem[i];
        div_y[i+1] <= div_y[i];
      end
    end
  end

  // Sign and saturation.
  assign lim   = neg_s[QUO_BITS] ? {1'b1, {(CENTER_WIDTH-1){1'b0}}}
                                 : {1'b0, {(CENTER_WIDTH-1){1'b1}}};
  assign over  = ovf_s[QUO_BITS] || (qacc[QUO_BITS] > QUO_BITS'(lim));
  assign q_low = qacc[QUO_BITS][CENTER_WIDTH-1:0];
  assign q     = over ? lim : (neg_s[QUO_BITS] ? -q_low : q_low);

endmodule

>>> src/scc_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_back: Cramer's rule solver
// Forms the cofactors of the edge matrix, the determinant and the three
// numerators, divides, and registers the result beat.
// ---------------------------------------------------------------------------
module scc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  scc_pkg::scc_sys_t  sys,
  output logic               done,
  output scc_pkg::scc_out_t  result
);
  import scc_pkg::*;

  localparam int BACK_LAT = 4 + MUL_STAGES + DIV_LAT;

  logic                           p1_valid;
  scc_sys_t                       p1_sys;
  prod_t                          pa [3][3];
  prod_t                          pb [3][3];
  logic                           p2_valid;
  cof_t                           cof [3][3];
  cof_t                           cof_next [3][3];
  diff_t                          p2_n0 [3];
  rhs_t                           p2_rhs [3];
  logic signed [DIFF_WIDTH+COF_WIDTH-1:0] den_p [3];
  logic signed [RHS_WIDTH+COF_WIDTH-1:0]  num_p [3][3];
  logic [MUL_STAGES-1:0]          mul_v;
  logic                           sum_valid;
  logic signed [DEN_WIDTH-1:0]    den_s;
  logic signed [NUM_WIDTH-1:0]    num_s [3];
  logic [DIV_LAT-1:0]             div_v;
  logic [DIV_LAT-1:0]             deg_v;
  center_t                        quo [3];

  // Products for the cyclic cofactors of the edge matrix.
  for (genvar k = 0; k < 3; k++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      always_ff @(posedge clk) begin
        pa[k][j] <= sys.n[K1][J1] * sys.n[K2][J2];
        pb[k][j] <= sys.n[K1][J2] * sys.n[K2][J1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= in_valid;
    end
    p1_sys <= sys;
  end

  // Cofactors; a triangle uses the 2x2 cofactors in the upper corner.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (p1_sys.three_d) begin
          cof_next[k][j] = COF_WIDTH'(pa[k][j]) - COF_WIDTH'(pb[k][j]);
        end else begin
          cof_next[k][j] = '0;
        end
      end
    end
    if (!p1_sys.three_d) begin
      cof_next[0][0] = COF_WIDTH'(p1_sys.n[1][1]);
      cof_next[1][0] = -COF_WIDTH'(p1_sys.n[0][1]);
      cof_next[0][1] = -COF_WIDTH'(p1_sys.n[1][0]);
      cof_next[1][1] = COF_WIDTH'(p1_sys.n[0][0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    cof <= cof_next;
    for (int k = 0; k < 3; k++) begin
      p2_n0[k]  <= p1_sys.n[k][0];
      p2_rhs[k] <= p1_sys.rhs[k];
    end
  end

  // Determinant along column 0; numerator j along column j.
  for (genvar k = 0; k < 3; k++) begin : g_mk
    scc_mul #(.AW(DIFF_WIDTH), .BW(COF_WIDTH)) u_den_mul (
      .clk (clk),
      .a   (p2_n0[k]),
      .b   (cof[k][0]),
      .p   (den_p[k])
    );
    for (genvar j = 0; j < 3; j++) begin : g_mj
      scc_mul #(.AW(RHS_WIDTH), .BW(COF_WIDTH)) u_num_mul (
        .clk (clk),
        .a   (p2_rhs[k]),
        .b   (cof[k][j]),
        .p   (num_p[j][k])
      );
    end
  end

  // Sums of the three terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v     <= '0;
      sum_valid <= 1'b0;
    end else begin
      mul_v     <= MUL_STAGES'({mul_v, p2_valid});
      sum_valid <= mul_v[MUL_STAGES-1];
    end
    den_s <= DEN_WIDTH'(den_p[0]) + DEN_WIDTH'(den_p[1]) + DEN_WIDTH'(den_p[2]);
    for (int j = 0; j < 3; j++) begin
      num_s[j] <= NUM_WIDTH'(num_p[j][0]) + NUM_WIDTH'(num_p[j][1])
                + NUM_WIDTH'(num_p[j][2]);
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_div
    scc_div #(.NUM_W(NUM_WIDTH), .DEN_W(DEN_WIDTH)) u_div (
      .clk (clk),
      .num (num_s[j]),
      .den (den_s),
      .q   (quo[j])
    );
  end

  // Valid and degenerate flags follow the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_v <= '0;
    end else begin
      div_v <= DIV_LAT'({div_v, sum_valid});
    end
    deg_v <= DIV_LAT'({deg_v, den_s == '0});
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_v[DIV_LAT-1];
    end
    result.degenerate <= deg_v[DIV_LAT-1];
    result.center_x   <= deg_v[DIV_LAT-1] ? '0 : quo[0];
    result.center_y   <= deg_v[DIV_LAT-1] ? '0 : quo[1];
    result.center_z   <= deg_v[DIV_LAT-1] ? '0 : quo[2];
  end

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.degenerate |->
      result.center_x == '0 && result.center_y == '0 && result.center_z == '0)
    else $error("degenerate result with nonzero center");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##BACK_LAT done)
    else $error("result beat missing after solver latency");

endmodule

>>> src/simplex_circumcenter_top.sv
`timescale 1ns / 1ps
// An accepted simplex passes the front, the queue and the back before done rises.
// Throughput: one simplex per cycle; the three 34-stage dividers and the digit
// multipliers are fully pipelined, so busy stays low in steady operation.
// Reset: synchronous, clears all valid flags and the queue; three_d = 1.
// The result beat is shown for one cycle; the receiver cannot stall it.
// ---------------------------------------------------------------------------
// simplex_circumcenter_top: circumcenter of a tetrahedron or triangle
// Command-style input, strobed result, APB mode register, front/back split.
// ---------------------------------------------------------------------------
module simplex_circumcenter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  scc_pkg::scc_in_t                    vertices,
  output logic                                done,
  output scc_pkg::scc_out_t                   result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [scc_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import scc_pkg::*;

  logic                  three_d;
  logic                  push;
  scc_sys_t              front_sys;
  logic                  q_valid;
  scc_sys_t              q_sys;
  logic [CNT_WIDTH-1:0]  q_count;
  logic                  reg_sel;

  // Mode register.
  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_IDX_BIT] == REG_THREE_D_IDX;
  assign prdata  = reg_sel ? {31'b0, three_d} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      three_d <= 1'b1;
    end else if (psel && penable && pwrite && reg_sel) begin
      three_d <= pwdata[0];
    end
  end

  scc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .vertices    (vertices),
    .three_d     (three_d),
    .queue_count (q_count),
    .push        (push),
    .sys         (front_sys)
  );

  scc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .sys_in  (front_sys),
    .valid   (q_valid),
    .sys_out (q_sys),
    .count   (q_count)
  );

  scc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .sys      (q_sys),
    .done     (done),
    .result   (result)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the simplex circumcenter engine
// Drives simplices through the command port, switches between tetrahedron
// and triangle mode over APB, and checks every result beat against a typed
// expectation or an exact wide-integer Cramer's rule predictor.
// ---------------------------------------------------------------------------
module tb_top;
  import scc_pkg::*;

  typedef logic signed [191:0] wide_t;

  // One row of the directed table.
  typedef struct {
    logic     mode;
    scc_in_t  simplex;
    bit       typed;
    scc_out_t center;
  } drow_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASE_ITEMS    = 270;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  scc_in_t                   vertices = '0;
  logic                      done;
  scc_out_t                  result;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;

  // Typed expectation travels with the beat so the monitor sees it race-free.
  logic     beat_typed = 1'b0;
  scc_out_t beat_center = '0;

  logic     mode_shadow = 1'b1;
  scc_out_t centers_due[$];
  int       errors = 0;
  int       beats_in = 0;
  int       beats_out = 0;
  int       degenerate_seen = 0;
  int       saturated_seen = 0;
  int       quiet_cycles = 0;

  simplex_circumcenter_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .vertices(vertices),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic wide_t det2(wide_t a, wide_t b, wide_t c, wide_t d);
    return a * d - b * c;
  endfunction

  function automatic wide_t det3(wide_t a, wide_t b, wide_t c, wide_t d, wide_t e,
                                 wide_t f, wide_t g, wide_t h, wide_t i);
    return a * det2(e, f, h, i) - b * det2(d, f, g, i) + c * det2(d, e, g, h);
  endfunction

  // Rounded num * 128 / den, ties away from zero, saturated to 32 bits.
  function automatic center_t scaled_quotient(wide_t num, wide_t den);
    logic          neg;
    logic [191:0]  an;
    logic [191:0]  ad;
    logic [191:0]  q;
    neg = (num < 0) != (den < 0);
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    q   = (an * 256 + ad) / (ad * 2);
    if (neg) begin
      if (q > 192'h8000_0000) return 32'h8000_0000;
      return center_t'(-q);
    end
    if (q > 192'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return center_t'(q);
  endfunction

  // Exact circumcenter of one simplex in the given mode.
  function automatic scc_out_t circumcenter(scc_in_t s, logic three_d);
    wide_t    v[4][3];
    wide_t    n[3][3];
    wide_t    rhs[3];
    wide_t    den, nx, ny, nz;
    scc_out_t c;
    v[0][0] = s.v0_x; v[0][1] = s.v0_y; v[0][2] = s.v0_z;
    v[1][0] = s.v1_x; v[1][1] = s.v1_y; v[1][2] = s.v1_z;
    v[2][0] = s.v2_x; v[2][1] = s.v2_y; v[2][2] = s.v2_z;
    v[3][0] = s.v3_x; v[3][1] = s.v3_y; v[3][2] = s.v3_z;
    for (int k = 0; k < 3; k++) begin
      rhs[k] = 0;
      for (int j = 0; j < 3; j++) begin
        n[k][j] = v[k+1][j] - v[0][j];
        if (j < 2 || three_d) rhs[k] += v[k+1][j] * v[k+1][j] - v[0][j] * v[0][j];
      end
    end
    if (three_d) begin
      den = det3(n[0][0], n[0][1], n[0][2], n[1][0], n[1][1], n[1][2],
                 n[2][0], n[2][1], n[2][2]);
      nx  = det3(rhs[0], n[0][1], n[0][2], rhs[1], n[1][1], n[1][2],
                 rhs[2], n[2][1], n[2][2]);
      ny  = det3(n[0][0], rhs[0], n[0][2], n[1][0], rhs[1], n[1][2],
                 n[2][0], rhs[2], n[2][2]);
      nz  = det3(n[0][0], n[0][1], rhs[0], n[1][0], n[1][1], rhs[1],
                 n[2][0], n[2][1], rhs[2]);
    end else begin
      den = det2(n[0][0], n[0][1], n[1][0], n[1][1]);
      nx  = det2(rhs[0], n[0][1], rhs[1], n[1][1]);
      ny  = det2(n[0][0], rhs[0], n[1][0], rhs[1]);
      nz  = 0;
    end
    c = '0;
    if (den == 0) begin
      c.degenerate = 1'b1;
      return c;
    end
    c.center_x = scaled_quotient(nx, den);
    c.center_y = scaled_quotient(ny, den);
    c.center_z = three_d ? scaled_quotient(nz, den) : '0;
    return c;
  endfunction

  // Monitor: record accepted simplices, check result beats, run the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start && !busy) begin
        beats_in <= beats_in + 1;
        centers_due.push_back(beat_typed ? beat_center : circumcenter(vertices, mode_shadow));
      end
      if (done) begin
        beats_out <= beats_out + 1;
        if (centers_due.size() == 0) begin
          $display("%0t: result beat with nothing expected: %p", $realtime, result);
          errors++;
        end else begin
          scc_out_t want;
          want = centers_due.pop_front();
          if (result.center_x !== want.center_x) begin
            $display("%0t: center_x expected %h actual %h", $realtime,
                     want.center_x, result.center_x);
            errors++;
          end
          if (result.center_y !== want.center_y) begin
            $display("%0t: center_y expected %h actual %h", $realtime,
                     want.center_y, result.center_y);
            errors++;
          end
          if (result.center_z !== want.center_z) begin
            $display("%0t: center_z expected %h actual %h", $realtime,
                     want.center_z, result.center_z);
            errors++;
          end
          if (result.degenerate !== want.degenerate) begin
            $display("%0t: degenerate expected %b actual %b", $realtime,
                     want.degenerate, result.degenerate);
            errors++;
          end
          if (want.degenerate) degenerate_seen++;
          if (want.center_x == 32'h7FFF_FFFF || want.center_x == 32'h8000_0000)
            saturated_seen++;
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $realtime);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Send one simplex beat and hold it until it is accepted.
  task automatic send_simplex(scc_in_t s, bit typed, scc_out_t c);
    vertices    <= s;
    beat_typed  <= typed;
    beat_center <= c;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Wait until every result has arrived and the pipeline has emptied.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (centers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drain results, then APB write of the mode register and read it back.
  task automatic set_mode(logic m);
    drain_results();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_ADDR_WIDTH'(REG_THREE_D_IDX) << CFG_IDX_BIT;
    pwdata <= {31'b0, m};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mode_shadow = m;
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== m) begin
      $display("%0t: mode readback expected %b actual %b", $realtime, m, prdata[0]);
      errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random simplex: mostly general, some exactly or nearly flat.
  function automatic scc_in_t rnd_simplex(logic three_d);
    scc_in_t s;
    int      pick;
    s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 10) begin
      if (three_d) begin
        s.v3_x = s.v2_x; s.v3_y = s.v2_y; s.v3_z = s.v2_z;
      end else begin
        s.v2_x = s.v1_x; s.v2_y = s.v1_y;
      end
    end else if (pick < 25) begin
      s.v2_x = s.v1_x + coord_t'($urandom_range(2)) - coord_t'(1);
      s.v2_y = s.v1_y + coord_t'($urandom_range(2)) - coord_t'(1);
      s.v3_x = s.v2_x + coord_t'($urandom_range(2)) - coord_t'(1);
      s.v3_y = s.v1_y;
      s.v3_z = s.v2_z + coord_t'($urandom_range(2)) - coord_t'(1);
    end else if (pick < 40) begin
      s.v1_x = s.v0_x + coord_t'($urandom_range(63)) - coord_t'(32);
      s.v1_y = s.v0_y + coord_t'($urandom_range(63)) - coord_t'(32);
      s.v2_x = s.v0_x + coord_t'($urandom_range(63)) - coord_t'(32);
      s.v2_y = s.v0_y + coord_t'($urandom_range(63)) - coord_t'(32);
    end
    return s;
  endfunction

  drow_t    dtab[$];
  scc_out_t zero_c;
  scc_out_t unit_c;
  scc_in_t  s;

  initial begin
    int idle_pct[5] = '{0, 77, 28, 0, 77};
    zero_c = '0;
    zero_c.degenerate = 1'b1;
    unit_c = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0};

    // Directed rows: coincident vertices, extremes, unit simplices, thin shapes.
    dtab.push_back('{1'b1, '0, 1'b1, zero_c});
    dtab.push_back('{1'b1, {12{16'h7FFF}}, 1'b1, zero_c});
    dtab.push_back('{1'b1, {12{16'h8000}}, 1'b1, zero_c});
    s = '0; s.v1_x = 16'd512; s.v2_y = 16'd512; s.v3_z = 16'd512;
    dtab.push_back('{1'b1, s, 1'b1, unit_c});
    dtab.push_back('{1'b1, {16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                           16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF},
                     1'b0, zero_c});
    dtab.push_back('{1'b1, {16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                           16'h8000, 16'h8001, 16'h8000, 16'h8000, 16'h8000, 16'h8001},
                     1'b0, zero_c});
    dtab.push_back('{1'b1, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
                           16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000},
                     1'b0, zero_c});
    dtab.push_back('{1'b1, {16'h0001, 16'hFFFF, 16'h0000, 16'h0002, 16'hFFFF, 16'h0000,
                           16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0001},
                     1'b0, zero_c});
    s = '0; s.v1_x = 16'd512; s.v2_y = 16'd512; s.v0_z = 16'h7FFF;
    s.v3_x = '1; s.v3_y = '1; s.v3_z = '1;
    dtab.push_back('{1'b0, s, 1'b1,
                     '{32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1'b0}});
    dtab.push_back('{1'b0, '0, 1'b1, zero_c});
    s = {12{16'h7FFF}}; s.v1_x = 16'h8000; s.v2_y = 16'h8000;
    dtab.push_back('{1'b0, s, 1'b0, zero_c});
    dtab.push_back('{1'b0, {16'h8000, 16'h8000, 16'h1234, 16'h7FFF, 16'h8000, 16'h5555,
                           16'h8000, 16'h8001, 16'hAAAA, 16'h1111, 16'h2222, 16'h3333},
                     1'b0, zero_c});
    dtab.push_back('{1'b0, {16'h0000, 16'h0000, 16'h0000, 16'h0003, 16'h0001, 16'h0000,
                           16'h0006, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
                     1'b1, zero_c});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part; the first rows run on the reset value of the mode.
    foreach (dtab[r]) begin
      if (dtab[r].mode !== mode_shadow) set_mode(dtab[r].mode);
      send_simplex(dtab[r].simplex, dtab[r].typed, dtab[r].center);
    end

    // Random phases, alternating mode and sender idling.
    for (int p = 0; p < 5; p++) begin
      set_mode(p[0] ? 1'b0 : 1'b1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_simplex(rnd_simplex(mode_shadow), 1'b0, zero_c);
        if ($urandom_range(99) < idle_pct[p]) begin
          start <= 1'b0;
          @(posedge clk);
          while ($urandom_range(99) < idle_pct[p]) @(posedge clk);
        end
      end
    end

    drain_results();
    $display("Checked %0d of %0d simplices in both modes: %0d degenerate, %0d saturated.",
             beats_out, beats_in, degenerate_seen, saturated_seen);
    if (errors == 0 && centers_due.size() == 0 && beats_out == beats_in) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
